>>> design/cstt_pkg.sv
package cstt_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LK_SCAN,
    S_LK_SHIFT,
    S_SW_SCAN
  } state_t;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;

  localparam logic [3:0] RES_REFRESHED = 4'd0;
  localparam logic [3:0] RES_NEWER     = 4'd1;
  localparam logic [3:0] RES_DROPPED   = 4'd2;
  localparam logic [3:0] RES_UNKNOWN   = 4'd3;
  localparam logic [3:0] RES_ADDED     = 4'd4;
  localparam logic [3:0] RES_FULL      = 4'd5;
  localparam logic [3:0] RES_ACTIVE    = 4'd6;
  localparam logic [3:0] RES_DISCONN   = 4'd7;
  localparam logic [3:0] RES_EMPTY     = 4'd8;

  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] session;
    logic [15:0] tag;
    logic [31:0] stamp;
  } entry_t;

endpackage

>>> design/cstt_ram.sv
module cstt_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/client_session_timeout_table.sv
// Client session table with timeout aging.
// Input words are taken on start while busy is low: in_opcode selects lookup,
// add or sweep; the key, session, tag and current time travel alongside.
// Each result word is shown for exactly one cycle with out_strobe high;
// out_last_item marks the final word of a command. The receiver cannot stall.
// cfg_we/cfg_wdata write the inactivity limit; write only while idle.
// Behaviour per command:
//   add: result in the cycle after accept, never busy.
//   lookup: result once the match or the last entry is read; a drop then
//     compacts the table, busy while the entries behind it move down.
//     Lookup of an empty table: result in the cycle after accept, never busy.
//   sweep: one word a cycle, from the first entry to the last, busy through
//     the walk; disconnected entries are squeezed out in place.
// All walks are paced by the entry RAM, one read and one write per cycle
// with a registered read. Opcode three is dropped with no result.
// Reset empties the table and loads the limit with 2000; RAM contents are
// left as they are and never read beyond the entry count.
module client_session_timeout_table #(
  parameter int MAX_CLIENTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_ip_addr,
  input  logic [15:0] in_port_num,
  input  logic [63:0] in_session_number,
  input  logic [15:0] in_client_tag,
  input  logic [31:0] in_now_time,
  output logic        out_strobe,
  output logic [3:0]  out_status,
  output logic [31:0] out_ip,
  output logic [15:0] out_port,
  output logic [15:0] out_tag,
  output logic        out_last_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  import cstt_pkg::*;

  localparam int IW = $clog2(MAX_CLIENTS);
  localparam int CW = $clog2(MAX_CLIENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLIENTS);

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ridx_r, ridx_nxt;
  logic [CW-1:0] didx_r, didx_nxt;
  logic [CW-1:0] widx_r, widx_nxt;
  logic          dv_r, dv_nxt;
  logic [15:0]   tmo_r;

  logic [31:0] req_ip_r;
  logic [15:0] req_port_r;
  logic [63:0] req_sess_r;
  logic [15:0] req_tag_r;
  logic [31:0] req_now_r;

  logic        out_strobe_r;
  logic [3:0]  out_status_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_port_r;
  logic [15:0] out_tag_r;
  logic        out_last_r;

  logic        res_valid;
  logic [3:0]  res_status;
  logic [31:0] res_ip;
  logic [15:0] res_port;
  logic [15:0] res_tag;
  logic        res_last;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        rd_ent;

  logic          accept;
  logic          hit, sess_lt, sess_gt, active, last_ent;
  logic [31:0]   age;
  logic [CW-1:0] didx_m1;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign hit      = (rd_ent.ip == req_ip_r) && (rd_ent.port == req_port_r);
  assign sess_lt  = rd_ent.session < req_sess_r;
  assign sess_gt  = rd_ent.session > req_sess_r;
  assign age      = req_now_r - rd_ent.stamp;
  assign active   = age < {16'd0, tmo_r};
  assign last_ent = (didx_r + CW'(1)) == cnt_r;
  assign didx_m1  = didx_r - CW'(1);

  cstt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_CLIENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ridx_r[IW-1:0]),
    .rdata (rd_ent)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && cnt_r != '0) begin
          if (in_opcode == OP_LOOKUP) begin
            state_nxt = S_LK_SCAN;
          end else if (in_opcode == OP_SWEEP) begin
            state_nxt = S_SW_SCAN;
          end
        end
      end
      S_LK_SCAN: begin
        if (dv_r) begin
          if (hit) begin
            if (!sess_lt && (sess_gt || !active)) begin
              state_nxt = S_LK_SHIFT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else if (last_ent) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LK_SHIFT: begin
        if (!dv_r && ridx_r == cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SW_SCAN: begin
        if (dv_r && last_ent) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    ridx_nxt   = ridx_r;
    didx_nxt   = didx_r;
    widx_nxt   = widx_r;
    dv_nxt     = 1'b0;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    ram_waddr  = didx_r[IW-1:0];
    ram_wdata  = rd_ent;
    res_valid  = 1'b0;
    res_status = RES_REFRESHED;
    res_ip     = rd_ent.ip;
    res_port   = rd_ent.port;
    res_tag    = rd_ent.tag;
    res_last   = 1'b1;

    // walk states issue one read a cycle up to the entry count
    if (state_r != S_IDLE && ridx_r < cnt_r) begin
      dv_nxt   = 1'b1;
      didx_nxt = ridx_r;
      ridx_nxt = ridx_r + CW'(1);
    end

    case (state_r)
      S_IDLE: begin
        ridx_nxt = '0;
        widx_nxt = '0;
        if (accept) begin
          res_ip   = in_ip_addr;
          res_port = in_port_num;
          res_tag  = in_client_tag;
          case (in_opcode)
            OP_LOOKUP: begin
              if (cnt_r == '0) begin
                res_valid  = 1'b1;
                res_status = RES_UNKNOWN;
              end
            end
            OP_ADD: begin
              res_valid = 1'b1;
              if (cnt_r >= MAX_CNT) begin
                res_status = RES_FULL;
              end else begin
                res_status        = RES_ADDED;
                ram_we            = 1'b1;
                ram_waddr         = cnt_r[IW-1:0];
                ram_wdata.ip      = in_ip_addr;
                ram_wdata.port    = in_port_num;
                ram_wdata.session = in_session_number;
                ram_wdata.tag     = in_client_tag;
                ram_wdata.stamp   = in_now_time;
                cnt_nxt           = cnt_r + CW'(1);
              end
            end
            OP_SWEEP: begin
              if (cnt_r == '0) begin
                res_valid  = 1'b1;
                res_status = RES_EMPTY;
                res_ip     = '0;
                res_port   = '0;
                res_tag    = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LK_SCAN: begin
        if (dv_r) begin
          if (hit) begin
            res_valid = 1'b1;
            dv_nxt    = 1'b0;
            if (sess_lt) begin
              res_status = RES_NEWER;
            end else if (sess_gt || !active) begin
              res_status = RES_DROPPED;
              // restart reads just past the hole
              ridx_nxt   = didx_r + CW'(1);
            end else begin
              res_status      = RES_REFRESHED;
              ram_we          = 1'b1;
              ram_wdata.stamp = req_now_r;
            end
          end else if (last_ent) begin
            res_valid  = 1'b1;
            res_status = RES_UNKNOWN;
            res_ip     = req_ip_r;
            res_port   = req_port_r;
            res_tag    = req_tag_r;
            dv_nxt     = 1'b0;
          end
        end
      end
      S_LK_SHIFT: begin
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = didx_m1[IW-1:0];
        end else if (ridx_r == cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_SW_SCAN: begin
        if (dv_r) begin
          res_valid  = 1'b1;
          res_status = active ? RES_ACTIVE : RES_DISCONN;
          res_last   = last_ent;
          if (active) begin
            // survivors are packed down to the write pointer
            ram_we    = 1'b1;
            ram_waddr = widx_r[IW-1:0];
            widx_nxt  = widx_r + CW'(1);
          end
          if (last_ent) begin
            cnt_nxt = active ? widx_r + CW'(1) : widx_r;
            dv_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      dv_r         <= 1'b0;
      tmo_r        <= TIMEOUT_RST;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      dv_r         <= dv_nxt;
      out_strobe_r <= res_valid;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r       <= ridx_nxt;
    didx_r       <= didx_nxt;
    widx_r       <= widx_nxt;
    out_status_r <= res_status;
    out_ip_r     <= res_ip;
    out_port_r   <= res_port;
    out_tag_r    <= res_tag;
    out_last_r   <= res_last;
    if (accept) begin
      req_ip_r   <= in_ip_addr;
      req_port_r <= in_port_num;
      req_sess_r <= in_session_number;
      req_tag_r  <= in_client_tag;
      req_now_r  <= in_now_time;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_ip        = out_ip_r;
  assign out_port      = out_port_r;
  assign out_tag       = out_tag_r;
  assign out_last_item = out_last_r;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("entry count above table size");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (didx_r < cnt_r))
    else $error("walk read beyond entry count");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_ADD && cnt_r < MAX_CNT) |=>
      (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("add did not grow the table");

  a_empty_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_SWEEP && cnt_r == '0) |=>
      (out_strobe && out_status == RES_EMPTY && out_last_item))
    else $error("sweep of empty table gave no empty word");
`endif

endmodule
